// ===== hw/rtl/twag_pkg.sv =====
// ============================================================================
// twag_pkg
// Shared widths, register codes and beat types of the tile wrap address
// generator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package twag_pkg;

  // Coordinate width of every register, input field and output address.
  localparam int unsigned COORD_BITS = 16;
  // Magnitude of (pixel - origin); one divider cell per bit.
  localparam int unsigned DIV_BITS   = COORD_BITS + 1;
  // Remainder width: a positive extent is at most 2^(COORD_BITS-1)-1.
  localparam int unsigned REM_BITS   = COORD_BITS - 1;
  // Config index width; leaves room for codes that map to no register.
  localparam int unsigned CFG_IDX_BITS = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIV_BITS-1:0]   quo_t;
  typedef logic [REM_BITS-1:0]   rem_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CfgOriginX = 4'd0,
    CfgOriginY = 4'd1,
    CfgExtentW = 4'd2,
    CfgExtentH = 4'd3,
    CfgDestW   = 4'd4,
    CfgDestH   = 4'd5,
    CfgSrcW    = 4'd6,
    CfgSrcH    = 4'd7
  } cfg_reg_e;

  // Configuration register file contents.
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t extent_w;
    coord_t extent_h;
    coord_t dest_w;
    coord_t dest_h;
    coord_t src_w;
    coord_t src_h;
  } cfg_t;

  // Beat travelling down the divider chain.
  typedef struct packed {
    coord_t dest_x;
    coord_t dest_y;
    logic   zero_fill;
    logic   neg_x;
    logic   neg_y;
    quo_t   quo_x;
    quo_t   quo_y;
    rem_t   rem_x;
    rem_t   rem_y;
  } div_item_t;

  // Beat after the floor fix-up, before origin add and clamp.
  typedef struct packed {
    coord_t dest_x;
    coord_t dest_y;
    logic   zero_fill;
    rem_t   wrap_x;
    rem_t   wrap_y;
  } wrap_item_t;

endpackage : twag_pkg

`default_nettype wire

// ===== hw/rtl/twag_if.sv =====
// ============================================================================
// twag_if
// Valid/ready channels of the tile wrap address generator: pixel in,
// address out, configuration write.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface twag_pixel_if;
  logic                    valid;
  logic                    ready;
  twag_pkg::coord_t        pixel_x;
  twag_pkg::coord_t        pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface : twag_pixel_if

interface twag_addr_if;
  logic                    valid;
  logic                    ready;
  twag_pkg::coord_t        dest_x;
  twag_pkg::coord_t        dest_y;
  logic                    zero_fill;
  twag_pkg::coord_t        source_x;
  twag_pkg::coord_t        source_y;

  modport source (output valid, output dest_x, output dest_y, output zero_fill,
                  output source_x, output source_y, input ready);
  modport sink   (input valid, input dest_x, input dest_y, input zero_fill,
                  input source_x, input source_y, output ready);
endinterface : twag_addr_if

interface twag_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [twag_pkg::CFG_IDX_BITS-1:0]     index;
  twag_pkg::coord_t                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : twag_cfg_if

`default_nettype wire

// ===== hw/rtl/tile_wrap_address_gen_core.sv =====
// ============================================================================
// tile_wrap_address_gen_core
// Repeat-wrap texture address generator: maps each output pixel into the
// source tile with a floored modulo per axis and clamps to the input image.
// ============================================================================
//
//  channel  | dir | beat payload                                   | notes
//  ---------+-----+------------------------------------------------+------------------
//  pix_i    | in  | pixel_x, pixel_y                               | valid/ready
//  addr_o   | out | dest_x, dest_y, zero_fill, source_x, source_y  | valid/ready
//  cfg_i    | in  | index, data                                    | always ready
//
//  One pixel beat per clock while addr_o is not stalled, through the
//  entry stage, one remainder cell per magnitude bit, fix-up, clamp/output.
//  The row of remainder cells sets the pipeline depth; each cell does one
//  restoring subtract per axis.
//  Every stage has its own valid and takes a beat when it is empty or its
//  successor moves, so bubbles collapse and a stall on addr_o backs up only
//  once the whole chain is full.
//  Pixels outside the output are accepted and dropped at the entry stage.
//  Reset clears all valids and loads the register defaults (image size 1,
//  everything else 0). Write config only while the chain is empty.
//
`timescale 1ns / 1ps
`default_nettype none

module tile_wrap_address_gen_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  twag_pixel_if.sink  pix_i,
  twag_addr_if.source addr_o,
  twag_cfg_if.sink    cfg_i
);
  import twag_pkg::*;

  cfg_t      cfg_q;
  rem_t      ext_x, ext_y;

  // Chain position 0 is the entry stage, position k+1 is cell k.
  div_item_t         chain_item  [DIV_BITS+1];
  logic [DIV_BITS:0] chain_valid;
  logic [DIV_BITS:0] chain_ready;

  // --------------------------------------------------------------------------
  // Configuration registers; indexes past the list are dropped.
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{src_w: coord_t'(1), src_h: coord_t'(1), default: '0};
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgOriginX: cfg_q.origin_x <= cfg_i.data;
        CfgOriginY: cfg_q.origin_y <= cfg_i.data;
        CfgExtentW: cfg_q.extent_w <= cfg_i.data;
        CfgExtentH: cfg_q.extent_h <= cfg_i.data;
        CfgDestW:   cfg_q.dest_w   <= cfg_i.data;
        CfgDestH:   cfg_q.dest_h   <= cfg_i.data;
        CfgSrcW:    cfg_q.src_w    <= cfg_i.data;
        CfgSrcH:    cfg_q.src_h    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Positive extents fit the remainder width; others only feed zero-fill beats.
  assign ext_x = cfg_q.extent_w[REM_BITS-1:0];
  assign ext_y = cfg_q.extent_h[REM_BITS-1:0];

  // --------------------------------------------------------------------------
  // Entry: range check, sign and magnitude of the distance to the origin.
  // --------------------------------------------------------------------------
  twag_entry u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .cfg_i   (cfg_q),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .item_o  (chain_item[0])
  );

  // --------------------------------------------------------------------------
  // Remainder chain: one cell per magnitude bit, MSB first.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
    twag_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ext_x_i (ext_x),
      .ext_y_i (ext_y),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .item_i  (chain_item[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .item_o  (chain_item[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Floor fix-up, origin add, clamp, output register.
  // --------------------------------------------------------------------------
  twag_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (chain_valid[DIV_BITS]),
    .ready_o (chain_ready[DIV_BITS]),
    .item_i  (chain_item[DIV_BITS]),
    .addr_o  (addr_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A zero-fill beat never carries a fetch address.
  a_zero_fill_no_addr : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    addr_o.valid && addr_o.zero_fill |-> (addr_o.source_x == '0) && (addr_o.source_y == '0)
  ) else $error("zero-fill beat with nonzero source address");

  // The input only stalls when the whole chain is backed up behind addr_o.
  a_stall_from_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> addr_o.valid && !addr_o.ready
  ) else $error("input stalled without an output stall");

  // A result leaves the output register only by being taken.
  a_no_lost_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(addr_o.valid) |-> $past(addr_o.ready)
  ) else $error("output beat dropped without handshake");

endmodule : tile_wrap_address_gen_core

`default_nettype wire

// ===== hw/rtl/twag_entry.sv =====
// ============================================================================
// twag_entry
// Entry stage: drop pixels outside the output, take the signed distance to
// the tile origin apart into sign and magnitude, flag zero fill.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twag_entry (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  twag_pixel_if.sink              pix_i,
  input  wire twag_pkg::cfg_t     cfg_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output twag_pkg::div_item_t     item_o
);
  import twag_pkg::*;

  localparam int unsigned DiffBits = COORD_BITS + 2;

  logic                valid_q;
  div_item_t           item_q;
  div_item_t           item_d;
  logic                in_range;
  logic [DiffBits-1:0] pos_x, neg_x, pos_y, neg_y;

  assign pix_i.ready = !valid_q || ready_i;

  // Both directions in parallel; the sign of one picks the magnitude.
  assign pos_x = {2'b00, pix_i.pixel_x} - {{2{cfg_i.origin_x[COORD_BITS-1]}}, cfg_i.origin_x};
  assign neg_x = {{2{cfg_i.origin_x[COORD_BITS-1]}}, cfg_i.origin_x} - {2'b00, pix_i.pixel_x};
  assign pos_y = {2'b00, pix_i.pixel_y} - {{2{cfg_i.origin_y[COORD_BITS-1]}}, cfg_i.origin_y};
  assign neg_y = {{2{cfg_i.origin_y[COORD_BITS-1]}}, cfg_i.origin_y} - {2'b00, pix_i.pixel_y};

  assign in_range = (pix_i.pixel_x < cfg_i.dest_w) && (pix_i.pixel_y < cfg_i.dest_h);

  always_comb begin
    item_d           = '0;
    item_d.dest_x    = pix_i.pixel_x;
    item_d.dest_y    = pix_i.pixel_y;
    item_d.zero_fill = cfg_i.extent_w[COORD_BITS-1] || (cfg_i.extent_w == '0) ||
                       cfg_i.extent_h[COORD_BITS-1] || (cfg_i.extent_h == '0);
    item_d.neg_x     = pos_x[DiffBits-1];
    item_d.neg_y     = pos_y[DiffBits-1];
    item_d.quo_x     = pos_x[DiffBits-1] ? neg_x[DIV_BITS-1:0] : pos_x[DIV_BITS-1:0];
    item_d.quo_y     = pos_y[DiffBits-1] ? neg_y[DIV_BITS-1:0] : pos_y[DIV_BITS-1:0];
    item_d.rem_x     = '0;
    item_d.rem_y     = '0;
  end

  // Drop pixels outside the output: accept the beat, load no valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      valid_q <= pix_i.valid && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : twag_entry

`default_nettype wire

// ===== hw/rtl/twag_cell.sv =====
// ============================================================================
// twag_cell
// One restoring remainder step per axis: shift in the next magnitude bit,
// subtract the extent when it fits, hand the beat to the next cell.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twag_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire twag_pkg::rem_t      ext_x_i,
  input  wire twag_pkg::rem_t      ext_y_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire twag_pkg::div_item_t item_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output twag_pkg::div_item_t      item_o
);
  import twag_pkg::*;

  logic              valid_q;
  div_item_t         item_q;
  div_item_t         item_d;
  logic [REM_BITS:0] trial_x, trial_y, diff_x, diff_y;

  assign ready_o = !valid_q || ready_i;

  assign trial_x = {item_i.rem_x, item_i.quo_x[DIV_BITS-1]};
  assign trial_y = {item_i.rem_y, item_i.quo_y[DIV_BITS-1]};
  assign diff_x  = trial_x - {1'b0, ext_x_i};
  assign diff_y  = trial_y - {1'b0, ext_y_i};

  always_comb begin
    item_d       = item_i;
    item_d.quo_x = {item_i.quo_x[DIV_BITS-2:0], 1'b0};
    item_d.quo_y = {item_i.quo_y[DIV_BITS-2:0], 1'b0};
    item_d.rem_x = (trial_x >= {1'b0, ext_x_i}) ? diff_x[REM_BITS-1:0]
                                                : trial_x[REM_BITS-1:0];
    item_d.rem_y = (trial_y >= {1'b0, ext_y_i}) ? diff_y[REM_BITS-1:0]
                                                : trial_y[REM_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : twag_cell

`default_nettype wire

// ===== hw/rtl/twag_finish.sv =====
// ============================================================================
// twag_finish
// Floor fix-up of the remainder, then origin add and clamp to the input
// image into the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twag_finish (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire twag_pkg::cfg_t      cfg_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire twag_pkg::div_item_t item_i,
  twag_addr_if.source              addr_o
);
  import twag_pkg::*;

  logic                wrap_valid_q;
  wrap_item_t          wrap_q;
  wrap_item_t          wrap_d;
  logic                wrap_ready;
  logic                out_valid_q;
  coord_t              dest_x_q, dest_y_q, src_x_q, src_y_q;
  logic                zero_fill_q;
  coord_t              src_x_d, src_y_d;
  logic [COORD_BITS:0] sum_x, sum_y;
  coord_t              hi_x, hi_y;

  assign wrap_ready = !out_valid_q || addr_o.ready;
  assign ready_o    = !wrap_valid_q || wrap_ready;

  // Negative distance with a nonzero remainder folds to extent - remainder.
  always_comb begin
    wrap_d.dest_x    = item_i.dest_x;
    wrap_d.dest_y    = item_i.dest_y;
    wrap_d.zero_fill = item_i.zero_fill;
    wrap_d.wrap_x    = (item_i.neg_x && (item_i.rem_x != '0))
                       ? cfg_i.extent_w[REM_BITS-1:0] - item_i.rem_x : item_i.rem_x;
    wrap_d.wrap_y    = (item_i.neg_y && (item_i.rem_y != '0))
                       ? cfg_i.extent_h[REM_BITS-1:0] - item_i.rem_y : item_i.rem_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_valid_q <= 1'b0;
    end else if (ready_o) begin
      wrap_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      wrap_q <= wrap_d;
    end
  end

  // A zero image size clamps like a size of one.
  assign hi_x  = (cfg_i.src_w == '0) ? '0 : cfg_i.src_w - coord_t'(1);
  assign hi_y  = (cfg_i.src_h == '0) ? '0 : cfg_i.src_h - coord_t'(1);
  assign sum_x = {2'b00, wrap_q.wrap_x} + {cfg_i.origin_x[COORD_BITS-1], cfg_i.origin_x};
  assign sum_y = {2'b00, wrap_q.wrap_y} + {cfg_i.origin_y[COORD_BITS-1], cfg_i.origin_y};

  always_comb begin
    if (wrap_q.zero_fill || sum_x[COORD_BITS]) begin
      src_x_d = '0;
    end else if (sum_x[COORD_BITS-1:0] > hi_x) begin
      src_x_d = hi_x;
    end else begin
      src_x_d = sum_x[COORD_BITS-1:0];
    end
    if (wrap_q.zero_fill || sum_y[COORD_BITS]) begin
      src_y_d = '0;
    end else if (sum_y[COORD_BITS-1:0] > hi_y) begin
      src_y_d = hi_y;
    end else begin
      src_y_d = sum_y[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wrap_ready) begin
      out_valid_q <= wrap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wrap_valid_q && wrap_ready) begin
      dest_x_q    <= wrap_q.dest_x;
      dest_y_q    <= wrap_q.dest_y;
      zero_fill_q <= wrap_q.zero_fill;
      src_x_q     <= src_x_d;
      src_y_q     <= src_y_d;
    end
  end

  assign addr_o.valid     = out_valid_q;
  assign addr_o.dest_x    = dest_x_q;
  assign addr_o.dest_y    = dest_y_q;
  assign addr_o.zero_fill = zero_fill_q;
  assign addr_o.source_x  = src_x_q;
  assign addr_o.source_y  = src_y_q;

endmodule : twag_finish

`default_nettype wire

// ===== dv/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for tile_wrap_address_gen_core. A directed table walks
// the reset state, extreme register values, zero fill, skipped pixels,
// ignored register indexes and clamping. Random phases follow, each with a
// fresh register setting. Each pixel beat is predicted in the bench or typed
// into the table, and each address beat is compared field by field, in order.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import twag_pkg::*;

  localparam int unsigned CLK_HALF        = 10;
  localparam int unsigned RESET_CYCLES    = 6;
  // Drain margin past the pipeline depth, for dropped pixels still in flight.
  localparam int unsigned DRAIN_CYCLES    = COORD_BITS + 16;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CfgIdxSpare = 4'd12;
  localparam logic [CFG_IDX_BITS-1:0] CfgIdxTop   = 4'd15;

  // One address beat as the block emits it.
  typedef struct packed {
    coord_t dest_x;
    coord_t dest_y;
    logic   zero_fill;
    coord_t source_x;
    coord_t source_y;
  } fetch_beat_t;

  localparam fetch_beat_t NO_BEAT = '0;

  // Directed rows: a register write, a pixel checked against the predictor,
  // a pixel with its address typed in, or a pixel that must yield no beat.
  typedef enum logic [1:0] {RowWrite, RowFetch, RowTyped, RowSkip} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    coord_t                   data;
    coord_t                   px;
    coord_t                   py;
    fetch_beat_t              want;
  } row_t;

  localparam int unsigned N_DIRECTED = 52;

  localparam row_t DIRECTED_PLAN [N_DIRECTED] = '{
    // Reset state: output size 0, so nothing comes out.
    '{RowSkip,  '0,         16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowSkip,  '0,         16'h0000, 16'hFFFF, 16'hFFFF, NO_BEAT},
    // Open an 8x8 output; extents are still 0, so zero fill.
    '{RowWrite, CfgDestW,   16'h0008, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgDestH,   16'h0008, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h0000, 16'h0000,
      '{16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000}},
    '{RowTyped, '0,         16'h0000, 16'h0007, 16'h0007,
      '{16'h0007, 16'h0007, 1'b1, 16'h0000, 16'h0000}},
    '{RowSkip,  '0,         16'h0000, 16'h0008, 16'h0000, NO_BEAT},
    '{RowSkip,  '0,         16'h0000, 16'h0000, 16'h0008, NO_BEAT},
    // Most negative width still selects zero fill.
    '{RowWrite, CfgExtentW, 16'h8000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentH, 16'h0005, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h0003, 16'h0003,
      '{16'h0003, 16'h0003, 1'b1, 16'h0000, 16'h0000}},
    // Zero height alone selects zero fill.
    '{RowWrite, CfgExtentW, 16'h0004, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentH, 16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h0005, 16'h0006,
      '{16'h0005, 16'h0006, 1'b1, 16'h0000, 16'h0000}},
    // Full-size output and input.
    '{RowWrite, CfgExtentH, 16'h0003, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgDestW,   16'hFFFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgDestH,   16'hFFFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgSrcW,    16'hFFFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgSrcH,    16'hFFFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h0000, 16'h0000,
      '{16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}},
    '{RowFetch, '0,         16'h0000, 16'hFFFF, 16'hFFFF, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'hFFFE, 16'hFFFE, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'h0005, 16'h0004, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'hAAAA, 16'h5555, NO_BEAT},
    // Extreme origins and the widest positive tile.
    '{RowWrite, CfgOriginX, 16'h8000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgOriginY, 16'h7FFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentW, 16'h7FFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'hFFFE, 16'h0001, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'h7FFF, 16'h8000, NO_BEAT},
    // Zero input size counts as 1: both axes clamp to 0.
    '{RowWrite, CfgSrcW,    16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgSrcH,    16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h04D2, 16'h10E1,
      '{16'h04D2, 16'h10E1, 1'b0, 16'h0000, 16'h0000}},
    // Writes to unused indexes; an alias onto dest_w or src_h would show here.
    '{RowWrite, CfgIdxSpare, 16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgIdxTop,  16'h0040, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h0100, 16'h0200,
      '{16'h0100, 16'h0200, 1'b0, 16'h0000, 16'h0000}},
    // Width 1 folds every column onto the origin.
    '{RowWrite, CfgOriginX, 16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgOriginY, 16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentW, 16'h0001, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentH, 16'h7FFF, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgSrcW,    16'h0010, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgSrcH,    16'h0020, 16'h0000, 16'h0000, NO_BEAT},
    '{RowTyped, '0,         16'h0000, 16'h1234, 16'h0000,
      '{16'h1234, 16'h0000, 1'b0, 16'h0000, 16'h0000}},
    '{RowFetch, '0,         16'h0000, 16'hFFFE, 16'h7FFF, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'h0033, 16'h0031, NO_BEAT},
    // Negative origin: wrapped columns fall below 0 and clamp.
    '{RowWrite, CfgOriginX, 16'hFFF0, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentW, 16'h0020, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgOriginY, 16'h0010, 16'h0000, 16'h0000, NO_BEAT},
    '{RowWrite, CfgExtentH, 16'h0008, 16'h0000, 16'h0000, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'h0000, 16'h0000, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'h0017, 16'h0003, NO_BEAT},
    '{RowFetch, '0,         16'h0000, 16'hFFFE, 16'hFFFE, NO_BEAT}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  twag_pixel_if pix_bus ();
  twag_addr_if  addr_bus ();
  twag_cfg_if   cfg_bus ();

  tile_wrap_address_gen_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .addr_o (addr_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow of the register file, kept in step with every accepted write.
  cfg_t          shadow_cfg;
  // Address beats still owed by the block, oldest first.
  fetch_beat_t   fetch_queue [$];

  bit            idle_on;      // both sides insert random gaps while set
  bit            px_open;      // pixel valid is currently high
  bit            cfg_open;     // config valid is currently high
  int unsigned   mismatch_count;
  int unsigned   beats_sent;
  int unsigned   beats_checked;
  int unsigned   fills_seen;
  int unsigned   settings_used;
  int unsigned   cycle_count;

  always #(CLK_HALF) clk_i = ~clk_i;

  // Hard stop: a hung handshake or a missing beat ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               fetch_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input coord_t got, input coord_t want,
                             input fetch_beat_t beat);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%04h want 0x%04h (pixel %0d,%0d)",
                                name, got, want, beat.dest_x, beat.dest_y));
    end
  endtask

  // Wrap one axis into [origin, origin + extent) with a floored modulo, then
  // clamp into the input image. A zero image size behaves as size 1.
  function automatic coord_t wrap_axis(input coord_t c, input coord_t origin,
                                       input coord_t extent, input coord_t size);
    longint org;
    longint ext;
    longint pos;
    longint hi;
    org = $signed(origin);
    ext = $signed(extent);
    pos = (longint'(c) - org) % ext;
    if (pos < 0) pos += ext;
    pos += org;
    hi = (size == 0) ? 0 : longint'(size) - 1;
    if (pos < 0) pos = 0;
    if (pos > hi) pos = hi;
    return coord_t'(pos);
  endfunction

  // Address beat that one pixel should produce; returns 0 for a skipped pixel.
  function automatic bit predict_fetch(input coord_t px, input coord_t py,
                                       output fetch_beat_t beat);
    beat        = '0;
    beat.dest_x = px;
    beat.dest_y = py;
    if (px >= shadow_cfg.dest_w || py >= shadow_cfg.dest_h) return 1'b0;
    if ($signed(shadow_cfg.extent_w) <= 0 || $signed(shadow_cfg.extent_h) <= 0) begin
      beat.zero_fill = 1'b1;
      return 1'b1;
    end
    beat.source_x = wrap_axis(px, shadow_cfg.origin_x, shadow_cfg.extent_w,
                              shadow_cfg.src_w);
    beat.source_y = wrap_axis(py, shadow_cfg.origin_y, shadow_cfg.extent_h,
                              shadow_cfg.src_h);
    return 1'b1;
  endfunction

  // Drive one register write and hold it until the port takes the beat.
  // Valid stays high so back-to-back writes run without a bubble.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t value);
    if (!cfg_open) settings_used++;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    cfg_open = 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CfgOriginX: shadow_cfg.origin_x = value;
      CfgOriginY: shadow_cfg.origin_y = value;
      CfgExtentW: shadow_cfg.extent_w = value;
      CfgExtentH: shadow_cfg.extent_h = value;
      CfgDestW:   shadow_cfg.dest_w   = value;
      CfgDestH:   shadow_cfg.dest_h   = value;
      CfgSrcW:    shadow_cfg.src_w    = value;
      CfgSrcH:    shadow_cfg.src_h    = value;
      default:    ;
    endcase
  endtask

  // Send one pixel beat after a random gap. Valid only drops when a gap
  // follows, so a burst keeps it high across beats.
  task automatic send_pixel(input coord_t px, input coord_t py);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (cfg_open) begin
      cfg_bus.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid   <= 1'b1;
    pix_bus.pixel_x <= px;
    pix_bus.pixel_y <= py;
    px_open = 1'b1;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Let the pipe run dry: every owed beat out, then a full latency more so a
  // skipped pixel still in flight cannot see a new register value.
  task automatic drain_chain();
    if (px_open) begin
      pix_bus.valid <= 1'b0;
      px_open = 1'b0;
    end
    while (fetch_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic coord_t pick_origin();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return coord_t'(int'($urandom_range(0, 128)) - 64);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly small positive tiles; about one in ten is zero or negative.
  function automatic coord_t pick_extent();
    case ($urandom_range(0, 9))
      0:       return coord_t'(-int'($urandom_range(0, 32768)));
      1:       return 16'h7FFF;
      2:       return 16'h0001;
      3:       return coord_t'($urandom_range(1, 32767));
      default: return coord_t'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic coord_t pick_dest();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return coord_t'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic coord_t pick_src();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      default: return coord_t'($urandom_range(1, 300));
    endcase
  endfunction

  // Most pixels land inside the output; the rest are anywhere in range.
  function automatic coord_t pick_pixel(input coord_t limit);
    if (limit == 0 || $urandom_range(0, 4) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, int'(limit) - 1));
  endfunction

  // Address sink: random back-pressure, then hold ready until a beat moves.
  initial begin : addr_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        addr_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      addr_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!addr_bus.valid) @(posedge clk_i);
    end
  end

  // Compare each accepted address beat with the oldest one owed.
  always @(posedge clk_i) begin : addr_check
    fetch_beat_t want;
    if (rst_ni && addr_bus.valid && addr_bus.ready) begin
      if (fetch_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat for pixel %0d,%0d",
                                  addr_bus.dest_x, addr_bus.dest_y));
      end else begin
        want = fetch_queue.pop_front();
        beats_checked++;
        if (want.zero_fill) fills_seen++;
        check_field("dest_x",    addr_bus.dest_x,            want.dest_x,    want);
        check_field("dest_y",    addr_bus.dest_y,            want.dest_y,    want);
        check_field("zero_fill", coord_t'(addr_bus.zero_fill),
                    coord_t'(want.zero_fill), want);
        check_field("source_x",  addr_bus.source_x,          want.source_x,  want);
        check_field("source_y",  addr_bus.source_y,          want.source_y,  want);
      end
    end
  end

  initial begin : stimulus
    row_t        row;
    fetch_beat_t beat;
    int unsigned phase;
    int unsigned n;

    // Quiet every input before reset lets go.
    pix_bus.valid   <= 1'b0;
    pix_bus.pixel_x <= '0;
    pix_bus.pixel_y <= '0;
    addr_bus.ready  <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= '0;
    cfg_bus.data    <= '0;
    idle_on        = 1'b1;
    shadow_cfg     = '0;
    shadow_cfg.src_w = 16'd1;
    shadow_cfg.src_h = 16'd1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Drain before the first write of each block of writes.
    foreach (DIRECTED_PLAN[r]) begin
      row = DIRECTED_PLAN[r];
      case (row.kind)
        RowWrite: begin
          if (!cfg_open) drain_chain();
          write_reg(row.idx, row.data);
        end
        RowTyped: begin
          send_pixel(row.px, row.py);
          fetch_queue.push_back(row.want);
        end
        RowSkip: begin
          send_pixel(row.px, row.py);
        end
        default: begin
          send_pixel(row.px, row.py);
          if (predict_fetch(row.px, row.py, beat)) fetch_queue.push_back(beat);
        end
      endcase
    end

    // Random phases: new setting of every register, then a stream of pixels.
    // Every third phase runs with no gaps on either side.
    for (phase = 0; phase < N_PHASES; phase++) begin
      drain_chain();
      idle_on = (phase % 3) != 2;
      write_reg(CfgOriginX, pick_origin());
      write_reg(CfgOriginY, pick_origin());
      write_reg(CfgExtentW, pick_extent());
      write_reg(CfgExtentH, pick_extent());
      write_reg(CfgDestW,   pick_dest());
      write_reg(CfgDestH,   pick_dest());
      write_reg(CfgSrcW,    pick_src());
      write_reg(CfgSrcH,    pick_src());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? CfgIdxSpare : CfgIdxTop,
                  coord_t'($urandom));
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_pixel(pick_pixel(shadow_cfg.dest_w), pick_pixel(shadow_cfg.dest_h));
        if (predict_fetch(pix_bus.pixel_x, pix_bus.pixel_y, beat)) begin
          fetch_queue.push_back(beat);
        end
      end
    end

    drain_chain();

    $display("Sent %0d pixel beats across %0d register settings.",
             beats_sent, settings_used);
    $display("Checked %0d address beats (%0d zero fill), %0d mismatches.",
             beats_checked, fills_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : testbench

// ===== filelist.f =====
hw/rtl/twag_pkg.sv
hw/rtl/twag_if.sv
hw/rtl/twag_entry.sv
hw/rtl/twag_cell.sv
hw/rtl/twag_finish.sv
hw/rtl/tile_wrap_address_gen_core.sv
dv/testbench.sv
